// ----- src/pplt_pkg.sv -----
// Shared types and constants for the periodic piecewise-linear table core.
package pplt_pkg;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] position;
		logic signed [31:0] level;
		logic [5:0]         slot;
	} pplt_in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [5:0]         slot_out;
		logic signed [31:0] removed_position;
		logic [1:0]         status;
	} pplt_out_t;

	localparam logic [1:0] KIND_EVAL      = 2'd0;
	localparam logic [1:0] KIND_ADD       = 2'd1;
	localparam logic [1:0] KIND_ERASE     = 2'd2;
	localparam logic [1:0] KIND_ERASE_ADD = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_SLOT  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Request to the shared restoring divider.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} pplt_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [32:0] remainder;
	} pplt_div_rsp_t;

endpackage

// ----- src/pplt_ram.sv -----
// Generic single-port RAM with a registered read.
module pplt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// A read in the cycle of a write returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- src/pplt_div.sv -----
// Shared unsigned restoring divider, one quotient bit per cycle.
module pplt_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pplt_pkg::pplt_div_req_t req,
	output pplt_pkg::pplt_div_rsp_t rsp
);
	import pplt_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] dsr_q;
	logic [33:0] trial;

	// Shift in the next dividend bit and try a subtraction.
	assign trial = {rem_q, quo_q[63]} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
			end else if (busy_q) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[31:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
endmodule

// ----- src/periodic_piecewise_linear_table_core.sv -----
// Top level of the periodic piecewise-linear table core.
// One transaction at a time: the core lowers in_ready from acceptance until its result is
// taken. Every request passes through dispatch; an add or an evaluate then goes through the
// shared divider for the wrap only when the period is set and the position lies outside
// [0, period), then through a binary search and a read of the slot found. An evaluate that
// does not hit a point exactly reads its left neighbor and, unless it clamps, goes through
// the divider once more for the interpolation fraction. An add moves each entry at or
// behind the slot up by one and then writes the point; an erase moves each entry after
// the slot down by one; an erase-then-add runs both in turn.
// All division goes through one bit-serial divider; each point store has one port.
module periodic_piecewise_linear_table_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [30:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  pplt_pkg::pplt_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pplt_pkg::pplt_out_t out_data
);
	import pplt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_WRAP, S_WRAP_W, S_SR_RD, S_SR_W, S_HIT_RD, S_HIT,
		S_ER_RD, S_ER_GET, S_ER_MV_RD, S_ER_MV_WR,
		S_AD_MV_RD, S_AD_MV_WR, S_AD_PUT,
		S_EV_RDL, S_EV_GETL, S_EV_PREP, S_EV_DIV, S_EV_DW, S_EV_MUL, S_EV_FIN,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [30:0]        period_q;
	logic [CW-1:0]      count_q;
	pplt_in_t           req_q;
	pplt_out_t          res_q;
	logic signed [31:0] tx_q;
	logic [CW-1:0]      lo_q, hi_q, idx_q, j_q;
	logic signed [33:0] x0_q, x1_q;
	logic signed [31:0] y0_q, y1_q;
	logic signed [33:0] den_q;
	logic signed [33:0] num_q;
	logic signed [33:0] dy_q;
	logic [16:0]        frac_q;
	logic signed [50:0] prod_q;

	// Point memories.
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [31:0]   pos_wd, lev_wd, pos_rd, lev_rd;

	pplt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_pos (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(pos_wd), .rdata(pos_rd));
	pplt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_lev (
		.clk(clk), .we(mem_we), .addr(mem_addr), .wdata(lev_wd), .rdata(lev_rd));

	// Divider.
	pplt_div_req_t div_req;
	pplt_div_rsp_t div_rsp;
	pplt_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic [CW-1:0]      mid;
	logic [CW:0]        mid_sum;
	logic [CW-1:0]      ridx, lidx;
	logic               wrap_needed;
	logic [31:0]        abs_pos;
	logic [32:0]        wrap_rem;
	logic               hit;
	logic               ev_direct;
	logic signed [33:0] num_clamped;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CW:1];
	// Right neighbor wraps to the first point, left neighbor to the last.
	assign ridx = (idx_q == count_q) ? '0 : idx_q;
	assign lidx = (idx_q == '0) ? count_q - CW'(1) : idx_q - CW'(1);
	assign wrap_needed = (period_q != '0) &&
		(req_q.position[31] || ($unsigned(req_q.position) >= {1'b0, period_q}));
	assign abs_pos = req_q.position[31] ? (32'd0 - req_q.position) : req_q.position;
	// Floored modulo correction of a negative dividend.
	assign wrap_rem = (req_q.position[31] && div_rsp.remainder != '0)
		? ({2'b0, period_q} - div_rsp.remainder) : div_rsp.remainder;
	assign hit = (idx_q < count_q) && (pos_rd == tx_q);
	// Clamped ends and empty or negative spans need no division.
	assign ev_direct = ((period_q == '0) && (idx_q == '0 || idx_q == count_q)) ||
		(den_q <= 34'sd0);
	assign num_clamped = num_q[33] ? '0 : ((num_q > den_q) ? den_q : num_q);

	// Memory address and write data.
	always_comb begin
		mem_we   = 1'b0;
		mem_addr = mid[AW-1:0];
		pos_wd   = pos_rd;
		lev_wd   = lev_rd;
		unique case (state_q)
			S_HIT_RD:   mem_addr = ridx[AW-1:0];
			S_ER_RD:    mem_addr = j_q[AW-1:0];
			S_ER_MV_RD: mem_addr = AW'(j_q + CW'(1));
			S_ER_MV_WR, S_AD_MV_WR: begin
				mem_we   = 1'b1;
				mem_addr = j_q[AW-1:0];
			end
			S_AD_MV_RD: mem_addr = AW'(j_q - CW'(1));
			S_AD_PUT: begin
				mem_we   = 1'b1;
				mem_addr = idx_q[AW-1:0];
				pos_wd   = tx_q;
				lev_wd   = req_q.level;
			end
			S_EV_RDL:   mem_addr = lidx[AW-1:0];
			default: ;
		endcase
	end

	// Divider start.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {32'd0, abs_pos};
		div_req.divisor  = {2'b0, period_q};
		if (state_q == S_WRAP) begin
			div_req.start = wrap_needed;
		end else if (state_q == S_EV_DIV) begin
			div_req.start    = !ev_direct;
			div_req.dividend = {15'd0, num_clamped[32:0], 16'd0};
			div_req.divisor  = den_q[32:0];
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			period_q <= '0;
			count_q  <= '0;
			req_q    <= '0;
			res_q    <= '0;
			tx_q     <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			idx_q    <= '0;
			j_q      <= '0;
			x0_q     <= '0;
			x1_q     <= '0;
			y0_q     <= '0;
			y1_q     <= '0;
			den_q    <= '0;
			num_q    <= '0;
			dy_q     <= '0;
			frac_q   <= '0;
			prod_q   <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						res_q <= '0;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (req_q.kind == KIND_ERASE || req_q.kind == KIND_ERASE_ADD) begin
						if (count_q == '0) begin
							res_q.status <= ST_EMPTY;
							state_q <= S_OUT;
						end else if (32'(req_q.slot) >= 32'(count_q)) begin
							res_q.status <= ST_SLOT;
							state_q <= S_OUT;
						end else begin
							j_q <= CW'(req_q.slot);
							state_q <= S_ER_RD;
						end
					end else if (req_q.kind == KIND_EVAL && count_q == '0) begin
						res_q.status <= ST_EMPTY;
						state_q <= S_OUT;
					end else begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (wrap_needed) begin
						state_q <= S_WRAP_W;
					end else begin
						tx_q <= req_q.position;
						lo_q <= '0;
						hi_q <= count_q;
						state_q <= S_SR_RD;
					end
				end
				S_WRAP_W: begin
					if (div_rsp.done) begin
						tx_q <= wrap_rem[31:0];
						lo_q <= '0;
						hi_q <= count_q;
						state_q <= S_SR_RD;
					end
				end
				S_SR_RD: begin
					if (lo_q < hi_q) begin
						state_q <= S_SR_W;
					end else begin
						idx_q <= lo_q;
						state_q <= S_HIT_RD;
					end
				end
				S_SR_W: begin
					if ($signed(pos_rd) < tx_q) begin
						lo_q <= mid + CW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SR_RD;
				end
				S_HIT_RD: state_q <= S_HIT;
				S_HIT: begin
					// Read data holds the entry at the slot found, or the first one.
					if (req_q.kind == KIND_EVAL) begin
						if (hit) begin
							res_q.value <= lev_rd;
							state_q <= S_OUT;
						end else begin
							x1_q <= 34'($signed(pos_rd)) +
								((idx_q == count_q) ? 34'(period_q) : 34'd0);
							y1_q <= lev_rd;
							state_q <= S_EV_RDL;
						end
					end else if (hit) begin
						// Replace only the level: the position is rewritten with itself.
						res_q.slot_out <= 6'(idx_q);
						state_q <= S_AD_PUT;
					end else if (count_q >= CW'(TABLE_DEPTH)) begin
						res_q.status <= ST_FULL;
						res_q.slot_out <= '0;
						state_q <= S_OUT;
					end else begin
						j_q <= count_q;
						state_q <= S_AD_MV_RD;
					end
				end
				S_ER_RD: state_q <= S_ER_GET;
				S_ER_GET: begin
					res_q.removed_position <= pos_rd;
					state_q <= S_ER_MV_RD;
				end
				S_ER_MV_RD: begin
					if (j_q + CW'(1) < count_q) begin
						state_q <= S_ER_MV_WR;
					end else begin
						count_q <= count_q - CW'(1);
						if (req_q.kind == KIND_ERASE_ADD) begin
							req_q.kind <= KIND_ADD;
							state_q <= S_WRAP;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_ER_MV_WR: begin
					j_q <= j_q + CW'(1);
					state_q <= S_ER_MV_RD;
				end
				S_AD_MV_RD: begin
					if (j_q > idx_q) begin
						state_q <= S_AD_MV_WR;
					end else begin
						count_q <= count_q + CW'(1);
						res_q.slot_out <= 6'(idx_q);
						state_q <= S_AD_PUT;
					end
				end
				S_AD_MV_WR: begin
					j_q <= j_q - CW'(1);
					state_q <= S_AD_MV_RD;
				end
				S_AD_PUT: state_q <= S_OUT;
				S_EV_RDL: state_q <= S_EV_GETL;
				S_EV_GETL: begin
					// Left neighbor, shifted down one period when it wraps.
					x0_q <= 34'($signed(pos_rd)) - ((idx_q == '0) ? 34'(period_q) : 34'd0);
					y0_q <= lev_rd;
					state_q <= S_EV_PREP;
				end
				S_EV_PREP: begin
					den_q <= x1_q - x0_q;
					num_q <= 34'(tx_q) - x0_q;
					dy_q  <= 34'(y1_q) - 34'(y0_q);
					state_q <= S_EV_DIV;
				end
				S_EV_DIV: begin
					if (ev_direct) begin
						res_q.value <= ((period_q == '0) && (idx_q == count_q)) ? y0_q : y1_q;
						state_q <= S_OUT;
					end else begin
						state_q <= S_EV_DW;
					end
				end
				S_EV_DW: begin
					if (div_rsp.done) begin
						frac_q <= div_rsp.quotient[16:0];
						state_q <= S_EV_MUL;
					end
				end
				S_EV_MUL: begin
					prod_q <= 51'(dy_q) * 51'($signed({1'b0, frac_q}));
					state_q <= S_EV_FIN;
				end
				S_EV_FIN: begin
					// Arithmetic shift floors the scaled product.
					res_q.value <= y0_q + prod_q[47:16];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- test/pplt_checker.sv -----
// Checker for the piecewise-linear table core: tracks the table and compares each result.
module pplt_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [30:0]         cfg_wdata,
	input  logic                in_valid,
	input  logic                in_ready,
	input  pplt_pkg::pplt_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  pplt_pkg::pplt_out_t out_data,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import pplt_pkg::*;

	localparam int DEPTH = 64;

	logic signed [31:0] tbl_pos [DEPTH];
	logic signed [31:0] tbl_lev [DEPTH];
	int                 tbl_count;
	longint             wrap_len;
	pplt_out_t          expected_q [$];

	// Floored modulo into [0, period) when the period is positive.
	function automatic longint wrap_position(longint x);
		longint r;
		if (wrap_len == 0 || (x >= 0 && x < wrap_len)) return x;
		r = x % wrap_len;
		if (r < 0) r += wrap_len;
		return r;
	endfunction

	function automatic int first_not_below(longint x);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (longint'(tbl_pos[mid]) < x) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic longint blend(longint tx, longint x0, longint y0, longint x1, longint y1);
		longint den;
		longint num;
		longint frac;
		longint prod;
		longint q;
		den = x1 - x0;
		num = tx - x0;
		if (den <= 0) return y1;
		if (num < 0) num = 0;
		if (num > den) num = den;
		frac = (num * 65536) / den;
		prod = (y1 - y0) * frac;
		if (prod >= 0) q = prod / 65536;
		else q = -((-prod + 65535) / 65536);
		return y0 + q;
	endfunction

	function automatic longint level_at(longint pos);
		longint tx;
		int     idx;
		int     n;
		n = tbl_count;
		tx = wrap_position(pos);
		idx = first_not_below(tx);
		if (idx < n && longint'(tbl_pos[idx]) == tx) return tbl_lev[idx];
		if (idx == 0) begin
			if (wrap_len == 0) return tbl_lev[0];
			return blend(tx, longint'(tbl_pos[n-1]) - wrap_len, tbl_lev[n-1],
				tbl_pos[0], tbl_lev[0]);
		end
		if (idx == n) begin
			if (wrap_len == 0) return tbl_lev[n-1];
			return blend(tx, tbl_pos[n-1], tbl_lev[n-1],
				longint'(tbl_pos[0]) + wrap_len, tbl_lev[0]);
		end
		return blend(tx, tbl_pos[idx-1], tbl_lev[idx-1], tbl_pos[idx], tbl_lev[idx]);
	endfunction

	function automatic void insert_point(input longint pos, input logic signed [31:0] lev,
			output logic [1:0] st, output logic [5:0] where);
		longint x;
		int     idx;
		x = wrap_position(pos);
		idx = first_not_below(x);
		where = '0;
		st = ST_OK;
		if (idx < tbl_count && longint'(tbl_pos[idx]) == x) begin
			tbl_lev[idx] = lev;
			where = idx[5:0];
		end else if (tbl_count >= DEPTH) begin
			st = ST_FULL;
		end else begin
			for (int i = tbl_count; i > idx; i--) begin
				tbl_pos[i] = tbl_pos[i-1];
				tbl_lev[i] = tbl_lev[i-1];
			end
			tbl_pos[idx] = x[31:0];
			tbl_lev[idx] = lev;
			tbl_count++;
			where = idx[5:0];
		end
	endfunction

	function automatic void remove_slot(input int s, output logic [1:0] st,
			output logic signed [31:0] gone);
		gone = '0;
		st = ST_OK;
		if (tbl_count == 0) st = ST_EMPTY;
		else if (s >= tbl_count) st = ST_SLOT;
		else begin
			gone = tbl_pos[s];
			for (int j = s; j + 1 < tbl_count; j++) begin
				tbl_pos[j] = tbl_pos[j+1];
				tbl_lev[j] = tbl_lev[j+1];
			end
			tbl_count--;
		end
	endfunction

	function automatic pplt_out_t apply_request(pplt_in_t req);
		pplt_out_t r;
		logic [1:0] st;
		logic [5:0] where;
		logic signed [31:0] gone;
		longint lv;
		r = '0;
		case (req.kind)
			KIND_EVAL: begin
				if (tbl_count == 0) r.status = ST_EMPTY;
				else begin
					lv = level_at(req.position);
					r.value = lv[31:0];
				end
			end
			KIND_ADD: begin
				insert_point(req.position, req.level, st, where);
				r.status = st;
				r.slot_out = where;
			end
			KIND_ERASE: begin
				remove_slot(req.slot, st, gone);
				r.status = st;
				r.removed_position = gone;
			end
			default: begin
				remove_slot(req.slot, st, gone);
				r.status = st;
				r.removed_position = gone;
				if (st == ST_OK) begin
					insert_point(req.position, req.level, st, where);
					r.status = st;
					r.slot_out = where;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Predict on accepted requests and compare accepted results.
	always @(posedge clk or negedge arst_n) begin
		pplt_out_t want;
		if (!arst_n) begin
			tbl_count = 0;
			wrap_len = 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_we) wrap_len = cfg_wdata;
			if (in_valid && in_ready) expected_q.push_back(apply_request(in_data));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) report_mismatch("unexpected result", 1, 0);
				else begin
					want = expected_q.pop_front();
					if (out_data.value !== want.value)
						report_mismatch("value", out_data.value, want.value);
					if (out_data.slot_out !== want.slot_out)
						report_mismatch("slot_out", out_data.slot_out, want.slot_out);
					if (out_data.removed_position !== want.removed_position)
						report_mismatch("removed_position", out_data.removed_position,
							want.removed_position);
					if (out_data.status !== want.status)
						report_mismatch("status", out_data.status, want.status);
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

// ----- test/tb.sv -----
// Testbench top for the periodic piecewise-linear table core: stimulus and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pplt_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [30:0] cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	pplt_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	pplt_out_t out_data;
	int        fail_count;
	int        pending;
	int        idle_cycles;
	bit        hold_off;
	int        hold_len;

	periodic_piecewise_linear_table_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	pplt_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver stalls on its own pattern; a long hold-off can be requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_len <= 0;
		end else if (hold_off || hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len <= hold_off ? 400 : hold_len - 1;
		end else begin
			out_ready <= ($urandom_range(0, 9) < 6) || (($urandom & 32'h3F) == 0);
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 40)) * 32'sh1000 - 32'sh10000;
		endcase
	endfunction

	task automatic send(input logic [1:0] k, input logic signed [31:0] p,
			input logic signed [31:0] l, input logic [5:0] s);
		in_data <= '{kind: k, position: p, level: l, slot: s};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic set_period(input logic [30:0] p);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			logic [1:0] k;
			k = $urandom_range(0, 9) < 4 ? KIND_EVAL : 2'($urandom_range(1, 3));
			send(k, pick_value(), $urandom, $urandom_range(0, 9) < 7
				? 6'($urandom_range(0, 20)) : 6'($urandom));
			if (burst == 0) begin
				gap();
				burst = $urandom_range(0, 12);
			end else burst--;
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		hold_off = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, bad slots, ends, replace at both ends, exact hits.
		send(KIND_EVAL, 32'sh10000, 0, 0);
		send(KIND_ERASE, 0, 0, 0);
		send(KIND_ERASE_ADD, 0, 32'sh5, 6'd63);
		send(KIND_ADD, 32'sh80000000, 32'sh7FFFFFFF, 0);
		send(KIND_ADD, 32'sh7FFFFFFF, 32'sh80000000, 0);
		send(KIND_ADD, 32'sh0, 32'sh10000, 0);
		send(KIND_ADD, 32'sh80000000, 32'sh20000, 0);
		send(KIND_ADD, 32'sh7FFFFFFF, -32'sh30000, 0);
		send(KIND_EVAL, 32'sh0, 0, 0);
		send(KIND_EVAL, 32'sh12345, 0, 0);
		send(KIND_EVAL, -32'sh4567, 0, 0);
		send(KIND_ERASE, 0, 0, 6'd63);
		send(KIND_ERASE_ADD, 32'sh8000, 32'sh100, 6'd1);
		send(KIND_ERASE, 0, 0, 6'd2);
		gap();

		// Fill to full, then overflow and replace.
		for (int i = 0; i < 66; i++) send(KIND_ADD, i * 32'sh800 - 32'sh4000, $urandom, 0);
		send(KIND_ADD, -32'sh4000, 32'sh1, 0);
		send(KIND_EVAL, 32'sh7FFFFFFF, 0, 0);
		send(KIND_EVAL, 32'sh80000000, 0, 0);
		in_valid <= 1'b0;

		// Long receiver hold-off while requests keep coming.
		hold_off <= 1'b1;
		@(posedge clk);
		hold_off <= 1'b0;
		for (int i = 0; i < 5; i++) send(KIND_EVAL, pick_value(), 0, 0);
		in_valid <= 1'b0;

		// Wrapping periods with interpolation across the seam, then the period cleared again.
		set_period(31'h0002_0000);
		random_phase(150);
		set_period(31'h7FFFFFFF);
		random_phase(150);
		set_period(31'h0000_0001);
		random_phase(80);
		set_period(31'($urandom_range(1, 32'h0030_0000)));
		random_phase(150);
		set_period(31'h0);
		for (int i = 0; i < 64; i++) send(KIND_ERASE, 0, 0, 0);
		random_phase(70);

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
